@@ hdl/box_blur_3x3_rgb_defines.svh @@
// Assertion macros for the box blur block.
`ifndef BOX_BLUR_3X3_RGB_DEFINES_SVH
`define BOX_BLUR_3X3_RGB_DEFINES_SVH

// checked outside reset
`define BB3_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");

// also checked while reset is held
`define BB3_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("%m: check failed");

`endif

@@ hdl/bb3_pkg.sv @@
package bb3_pkg;

  localparam int unsigned CFG_W      = 11;
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned DIM_RESET  = 800;
  localparam int unsigned DIM_MIN    = 3;

  localparam int unsigned PIX_W   = 32;
  localparam int unsigned COORD_W = 10;
  localparam int unsigned ROW_W   = 10;
  localparam int unsigned SUM_W   = 12;

  // floor(s * 11 / 100) == (s * 57673) >> 19 for all s <= 2295
  localparam int unsigned RECIP  = 57673;
  localparam int unsigned SHIFT  = 19;
  localparam int unsigned PROD_W = 28;

  localparam int unsigned FIFO_DEPTH = 16;
  localparam int unsigned FIFO_AW    = 4;
  localparam int unsigned FIFO_CW    = 5;
  localparam int unsigned RES_MAX    = 3;

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic               run_last;
    logic               frame_last;
    logic [ROW_W-1:0]   row;
    logic [COORD_W-1:0] col;
    logic [7:0]         ch3;
    logic [7:0]         ch2;
    logic [7:0]         ch1;
    logic [7:0]         ch0;
  } res_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum2;
    logic [SUM_W-1:0] sum1;
    logic [SUM_W-1:0] sum0;
    logic [PIX_W-1:0] center;
  } win_t;

  function automatic logic [7:0] blur_scale(logic [SUM_W-1:0] s);
    logic [PROD_W-1:0] p;
    p = PROD_W'(s) * PROD_W'(RECIP);
    return p[SHIFT+7:SHIFT];
  endfunction

endpackage

@@ hdl/bb3_line_mem.sv @@
// Both line buffers in one word: {two rows up, one row up}.
module bb3_line_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [63:0]   wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [63:0]   rd_data_o
);

  logic [63:0] mem [DEPTH];
  logic [63:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hdl/bb3_window.sv @@
// Six-pixel window (two previous columns) plus the incoming column.
module bb3_window (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   shift_i,
  input  logic [31:0]            a_i,
  input  logic [31:0]            b_i,
  input  logic [31:0]            pix_i,
  output bb3_pkg::win_t          win_o
);

  logic [31:0] win_q [6];
  logic [31:0] nine [9];
  logic [bb3_pkg::SUM_W-1:0] sums [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (shift_i) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= a_i;
      win_q[4] <= b_i;
      win_q[5] <= pix_i;
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      nine[i] = win_q[i];
    end
    nine[6] = a_i;
    nine[7] = b_i;
    nine[8] = pix_i;
    for (int ch = 0; ch < 3; ch++) begin
      sums[ch] = '0;
      for (int k = 0; k < 9; k++) begin
        sums[ch] = sums[ch] + bb3_pkg::SUM_W'(nine[k][8*ch +: 8]);
      end
    end
  end

  assign win_o.sum0   = sums[0];
  assign win_o.sum1   = sums[1];
  assign win_o.sum2   = sums[2];
  assign win_o.center = win_q[4];

endmodule

@@ hdl/bb3_out_fifo.sv @@
// Result queue: up to three pushes per cycle, one pop.
module bb3_out_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [bb3_pkg::RES_MAX-1:0]   push_i,
  input  bb3_pkg::res_t                 push_data_i [bb3_pkg::RES_MAX],
  input  logic                          pop_i,
  output bb3_pkg::res_t                 head_o,
  output logic                          valid_o,
  output logic [bb3_pkg::FIFO_CW-1:0]   count_o
);

  bb3_pkg::res_t mem [bb3_pkg::FIFO_DEPTH];

  logic [bb3_pkg::FIFO_AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [bb3_pkg::FIFO_CW-1:0] count_q, count_d;
  logic [bb3_pkg::FIFO_AW-1:0] addr1, addr2;
  logic [1:0]                  n_push;

  assign n_push = 2'(push_i[0]) + 2'(push_i[1]) + 2'(push_i[2]);
  assign addr1  = tail_q + bb3_pkg::FIFO_AW'(push_i[0]);
  assign addr2  = addr1 + bb3_pkg::FIFO_AW'(push_i[1]);

  always_comb begin
    tail_d  = tail_q + bb3_pkg::FIFO_AW'(n_push);
    head_d  = head_q + bb3_pkg::FIFO_AW'(pop_i);
    count_d = count_q + bb3_pkg::FIFO_CW'(n_push) - bb3_pkg::FIFO_CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i[0]) begin
      mem[tail_q] <= push_data_i[0];
    end
    if (push_i[1]) begin
      mem[addr1] <= push_data_i[1];
    end
    if (push_i[2]) begin
      mem[addr2] <= push_data_i[2];
    end
  end

  assign head_o  = mem[head_q];
  assign valid_o = (count_q != '0);
  assign count_o = count_q;

endmodule

@@ hdl/box_blur_3x3_rgb.sv @@
// Channel  Dir  Transfer when         Payload
// s_axis   in   tvalid & tready       tdata: ch0, ch1, ch2, ch3
// m_axis   out  tvalid & tready       tdata: ch0..ch3, col, row; tlast: run_last;
//                                     tuser: frame_last
// cfg      in   cfg_we_i              cfg_idx_i selects width (0) or height (1)
//
// One pixel per cycle in while s_axis_tready is high; its results pass the line
// memory read, the window sum and the scale multiply, are then written to the
// result queue, and leave it from its head. Results leave at one per cycle while
// m_axis_tready is high, so row ends (two results) and the last row (two per
// pixel, three at its end) hold s_axis_tready low while the queue fills.
// Reset clears counters, window and queue; line memory is not cleared.
module box_blur_3x3_rgb #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // ch0, ch1, ch2, ch3
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // ch0, ch1, ch2, ch3, col[9:0], row[9:0], 4'b0
  output logic        m_axis_tlast,   // run_last
  output logic        m_axis_tuser,   // frame_last
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [10:0] cfg_wdata_i
);

  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMPW = (WW > bb3_pkg::CFG_W) ? WW : bb3_pkg::CFG_W;
  localparam int unsigned HW   = bb3_pkg::CFG_W;

  typedef struct packed {
    logic          c_ge1;
    logic          r_ge1;
    logic          interior;
    logic          last_col;
    logic          last_row;
    logic [CW-1:0] col;
    logic [9:0]    row;
  } pos_t;

  // ---------------- configuration ----------------
  logic [bb3_pkg::CFG_W-1:0] fw_q, fh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= bb3_pkg::CFG_W'(bb3_pkg::DIM_RESET);
      fh_q <= bb3_pkg::CFG_W'(bb3_pkg::DIM_RESET);
    end else if (cfg_we_i) begin
      unique case (bb3_pkg::cfg_idx_e'(cfg_idx_i))
        bb3_pkg::CFG_FRAME_WIDTH:  fw_q <= cfg_wdata_i;
        bb3_pkg::CFG_FRAME_HEIGHT: fh_q <= cfg_wdata_i;
        default:                   fw_q <= fw_q;
      endcase
    end
  end

  logic [CMPW-1:0] fw_ext, w;
  logic [HW-1:0]   h;

  assign fw_ext = CMPW'(fw_q);

  always_comb begin
    if (fw_ext < CMPW'(bb3_pkg::DIM_MIN)) begin
      w = CMPW'(bb3_pkg::DIM_MIN);
    end else if (fw_ext > CMPW'(MAX_WIDTH)) begin
      w = CMPW'(MAX_WIDTH);
    end else begin
      w = fw_ext;
    end
    if (fh_q < HW'(bb3_pkg::DIM_MIN)) begin
      h = HW'(bb3_pkg::DIM_MIN);
    end else if (fh_q > HW'(bb3_pkg::MAX_HEIGHT)) begin
      h = HW'(bb3_pkg::MAX_HEIGHT);
    end else begin
      h = fh_q;
    end
  end

  // ---------------- stage 0: position, memory read ----------------
  logic [CW-1:0]                col_q, col_d, c0;
  logic [9:0]                   row_q, row_d, r0;
  logic [HW-1:0]                r_inc, r_post;
  logic [CMPW-1:0]              c_plus;
  logic                         in_xfer;
  logic                         v1_q, v2_q;
  logic [bb3_pkg::FIFO_CW-1:0]  fifo_cnt;
  logic [bb3_pkg::FIFO_CW+1:0]  need;
  pos_t                         pos0;

  // room for three results from each item in flight plus the new one
  assign need = (bb3_pkg::FIFO_CW+2)'(fifo_cnt)
              + (bb3_pkg::FIFO_CW+2)'(3 * (32'(v1_q) + 32'(v2_q) + 1));
  assign s_axis_tready = (need <= (bb3_pkg::FIFO_CW+2)'(bb3_pkg::FIFO_DEPTH));
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  always_comb begin
    // counters may lie past a size that changed while idle
    if (CMPW'(col_q) >= w) begin
      c0    = '0;
      r_inc = HW'(row_q) + HW'(1);
    end else begin
      c0    = col_q;
      r_inc = HW'(row_q);
    end
    r0 = (r_inc >= h) ? '0 : r_inc[9:0];

    c_plus = CMPW'(c0) + CMPW'(1);
    r_post = HW'(r0) + HW'(1);
    if (c_plus >= w) begin
      col_d = '0;
      row_d = (r_post >= h) ? '0 : r_post[9:0];
    end else begin
      col_d = c_plus[CW-1:0];
      row_d = r0;
    end

    pos0.col      = c0;
    pos0.row      = r0;
    pos0.c_ge1    = (c0 != '0);
    pos0.r_ge1    = (r0 != '0);
    pos0.interior = (c0 >= CW'(2)) && (r0 >= 10'd2);
    pos0.last_col = (CMPW'(c0) == w - CMPW'(1));
    pos0.last_row = (HW'(r0) == h - HW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_xfer) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------- stage 1: line data, window, sums ----------------
  pos_t        pos1_q;
  logic [31:0] pix1_q;
  logic [63:0] rd_data;
  logic [31:0] a1, b1;
  bb3_pkg::win_t win;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pos1_q <= pos0;
      pix1_q <= s_axis_tdata;
    end
  end

  assign a1 = rd_data[63:32];
  assign b1 = rd_data[31:0];

  // an entry is reused only a full row later, so write and read never collide
  bb3_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_mem (
    .clk_i     (clk_i),
    .wr_en_i   (v1_q),
    .wr_addr_i (pos1_q.col),
    .wr_data_i ({b1, pix1_q}),
    .rd_en_i   (in_xfer),
    .rd_addr_i (c0),
    .rd_data_o (rd_data)
  );

  bb3_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (v1_q),
    .a_i     (a1),
    .b_i     (b1),
    .pix_i   (pix1_q),
    .win_o   (win)
  );

  // ---------------- stage 2: scale, emit ----------------
  pos_t          pos2_q;
  bb3_pkg::win_t win2_q;
  logic [31:0]   b2_q, pix2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      pos2_q <= pos1_q;
      win2_q <= win;
      b2_q   <= b1;
      pix2_q <= pix1_q;
    end
  end

  logic [31:0]   centre_px;
  logic [2:0]    push;
  bb3_pkg::res_t res [bb3_pkg::RES_MAX];
  bb3_pkg::res_t head;
  logic          pop;

  always_comb begin
    if (pos2_q.interior) begin
      centre_px = {win2_q.center[31:24],
                   bb3_pkg::blur_scale(win2_q.sum2),
                   bb3_pkg::blur_scale(win2_q.sum1),
                   bb3_pkg::blur_scale(win2_q.sum0)};
    end else begin
      centre_px = win2_q.center;
    end

    push[0] = v2_q && pos2_q.r_ge1 && pos2_q.c_ge1;
    push[1] = v2_q && pos2_q.r_ge1 && pos2_q.last_col;
    push[2] = v2_q && pos2_q.last_row;

    // pixel left of and above the input
    {res[0].ch3, res[0].ch2, res[0].ch1, res[0].ch0} = centre_px;
    res[0].col        = 10'(pos2_q.col - CW'(1));
    res[0].row        = pos2_q.row - 10'd1;
    res[0].frame_last = 1'b0;
    res[0].run_last   = !(push[1] || push[2]);

    // right border pixel of the row above
    {res[1].ch3, res[1].ch2, res[1].ch1, res[1].ch0} = b2_q;
    res[1].col        = 10'(pos2_q.col);
    res[1].row        = pos2_q.row - 10'd1;
    res[1].frame_last = 1'b0;
    res[1].run_last   = !push[2];

    // bottom row passes straight through
    {res[2].ch3, res[2].ch2, res[2].ch1, res[2].ch0} = pix2_q;
    res[2].col        = 10'(pos2_q.col);
    res[2].row        = pos2_q.row;
    res[2].frame_last = pos2_q.last_col;
    res[2].run_last   = 1'b1;
  end

  assign pop = m_axis_tvalid && m_axis_tready;

  bb3_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res),
    .pop_i       (pop),
    .head_o      (head),
    .valid_o     (m_axis_tvalid),
    .count_o     (fifo_cnt)
  );

  assign m_axis_tdata = {4'b0, head.row, head.col, head.ch3, head.ch2, head.ch1, head.ch0};
  assign m_axis_tlast = head.run_last;
  assign m_axis_tuser = head.frame_last;

endmodule

@@ hdl/bb3_checker.sv @@
`include "box_blur_3x3_rgb_defines.svh"

module bb3_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  // a stalled input holds
  `BB3_ASSERT(a_in_hold, s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))

  // a stalled result holds
  `BB3_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

  // end of frame always closes the run of its input
  `BB3_ASSERT(a_frame_last_run, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)

  // frame end sits on the last column, which is at least 2
  `BB3_ASSERT(a_frame_last_col, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[41:33] != 9'd0)

  // queue is empty right after reset
  `BB3_ASSERT_RST(a_reset_empty, !rst_ni |=> !m_axis_tvalid)

endmodule

bind box_blur_3x3_rgb bb3_checker u_bb3_checker (.*);
